/* design/mesh_bounding_box_fit_macros.svh */
`ifndef MESH_BOUNDING_BOX_FIT_MACROS_SVH
`define MESH_BOUNDING_BOX_FIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MBBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MBBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mbbf_pkg.sv */
package mbbf_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int COORD_W = 32;
  localparam int INDEX_W = 12;
  localparam int DIV_W   = 48;
  localparam int DVS_W   = 32;
  localparam int MUL_W   = 16;

  localparam logic [31:0] UNIT_SCALE = 32'h0001_0000;
  localparam logic [15:0] HALF_LSB   = 16'h8000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FIT   = 2'd1,
    OP_FETCH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_NO_USABLE   = 3'd1,
    STS_ZERO_EXTENT = 3'd2,
    STS_SCALE_RANGE = 3'd3,
    STS_OVERFLOW    = 3'd4,
    STS_BAD_FETCH   = 3'd5
  } status_t;

  typedef enum logic {
    KIND_FIT    = 1'b0,
    KIND_VERTEX = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_CENTER_Z = 3'd3,
    REG_MIRROR_Y = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXTENT,
    S_DIVIDE,
    S_FETCH,
    S_XFORM,
    S_EMIT
  } fsm_t;

  typedef enum logic [2:0] {
    X_IDLE,
    X_DIFF,
    X_MLO,
    X_MHI,
    X_SUM,
    X_FIN
  } xf_state_t;

  typedef struct packed {
    logic        start;
    logic        mirror;
    logic [31:0] scale;
  } xf_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

/* design/mbbf_in_if.sv */
interface mbbf_in_if;
  import mbbf_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  coord_t             vertex_x;
  coord_t             vertex_y;
  coord_t             vertex_z;
  logic               vertex_usable;
  logic [INDEX_W-1:0] fetch_index;

  modport source(output valid, operation, vertex_x, vertex_y, vertex_z, vertex_usable,
                 fetch_index, input ready);
  modport sink(input valid, operation, vertex_x, vertex_y, vertex_z, vertex_usable,
               fetch_index, output ready);
endinterface

/* design/mbbf_out_if.sv */
interface mbbf_out_if;
  import mbbf_pkg::*;

  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  status;
  coord_t      out_x;
  coord_t      out_y;
  coord_t      out_z;
  logic [31:0] fit_scale;

  modport source(output valid, result_kind, status, out_x, out_y, out_z, fit_scale,
                 input ready);
  modport sink(input valid, result_kind, status, out_x, out_y, out_z, fit_scale,
               output ready);
endinterface

/* design/mbbf_ram.sv */
module mbbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/mbbf_div.sv */
module mbbf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mbbf_pkg::DIV_W-1:0] dividend,
  input  logic [mbbf_pkg::DVS_W-1:0] divisor,
  output mbbf_pkg::unit_sts_t       sts,
  output logic [mbbf_pkg::DIV_W-1:0] quotient
);
  import mbbf_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DIV_W-1:0] q_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_r, q_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;
endmodule

/* design/mbbf_xform.sv */
module mbbf_xform (
  input  logic              clk,
  input  logic              rst_n,
  input  mbbf_pkg::xf_ctl_t ctl,
  input  mbbf_pkg::coord_t  vtx [3],
  input  mbbf_pkg::coord_t  mid [3],
  input  mbbf_pkg::coord_t  center [3],
  output mbbf_pkg::unit_sts_t sts,
  output mbbf_pkg::coord_t  res [3]
);
  import mbbf_pkg::*;

  xf_state_t          st_r, st_nxt;
  logic [1:0]         k_r;
  logic               done_r;
  logic [32:0]        mag_r;
  logic               neg_r;
  logic [48:0]        acc_r;
  logic [48:0]        phi_r;
  logic [32:0]        rnd_r;
  logic signed [50:0] sgn_r;

  coord_t             v_sel, m_sel, c_sel;
  logic signed [32:0] d;
  logic [MUL_W-1:0]   mul_b;
  logic [48:0]        prod;
  logic [48:0]        rsum;
  logic [49:0]        p;
  logic signed [50:0] t;
  logic               flip;

  assign v_sel = vtx[k_r];
  assign m_sel = mid[k_r];
  assign c_sel = center[k_r];
  assign flip  = ctl.mirror && (k_r == 2'd1);
  assign d     = flip ? ({m_sel[31], m_sel} - {v_sel[31], v_sel})
                      : ({v_sel[31], v_sel} - {m_sel[31], m_sel});

  // One 33x16 multiplier, used for the low and then the high half of the scale.
  assign mul_b = (st_r == X_MLO) ? ctl.scale[15:0] : ctl.scale[31:16];
  assign prod  = 49'(mag_r * mul_b);
  assign rsum  = acc_r + 49'(HALF_LSB);
  assign p     = 50'(phi_r) + 50'(rnd_r);
  assign t     = sgn_r + {{19{c_sel[31]}}, c_sel};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      X_IDLE: if (ctl.start) st_nxt = X_DIFF;
      X_DIFF: st_nxt = X_MLO;
      X_MLO:  st_nxt = X_MHI;
      X_MHI:  st_nxt = X_SUM;
      X_SUM:  st_nxt = X_FIN;
      X_FIN:  st_nxt = (k_r == 2'd2) ? X_IDLE : X_DIFF;
      default: st_nxt = X_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= X_IDLE;
      k_r    <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == X_FIN) && (k_r == 2'd2);
      if (st_r == X_IDLE) begin
        k_r <= '0;
      end else if (st_r == X_FIN) begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      X_DIFF: begin
        neg_r <= d[32];
        mag_r <= d[32] ? 33'(~d + 33'd1) : 33'(d);
      end
      X_MLO: acc_r <= prod;
      X_MHI: begin
        phi_r <= prod;
        rnd_r <= rsum[48:16];
      end
      X_SUM: sgn_r <= neg_r ? -$signed({1'b0, p}) : $signed({1'b0, p});
      X_FIN: begin
        if (t[50:31] != {20{t[50]}}) begin
          res[k_r] <= t[50] ? coord_t'(32'h8000_0000) : coord_t'(32'h7FFF_FFFF);
        end else begin
          res[k_r] <= t[31:0];
        end
      end
      default: ;
    endcase
  end

  assign sts.busy = (st_r != X_IDLE);
  assign sts.done = done_r;
endmodule

/* design/mesh_bounding_box_fit.sv */
// Channel   Role    Beat contents
// in_ch     sink    operation, vertex_x/y/z, vertex_usable, fetch_index
// out_ch    source  result_kind, status, out_x/y/z, fit_scale
// cfg_*     write   cfg_we, cfg_index, cfg_wdata (no read-back)
//
// Loads stream at one beat per cycle while the block is idle.
// A bad-index fetch skips to emit; otherwise, unless pass-through, a fetch runs
// the transform: three coordinates, five steps each through one 33x16 multiplier.
// A fit that is not settled early runs the 48-step radix-2 divider.
// Reset is synchronous and active low; the vertex store is not cleared.
// A result waits in the output register while the input side keeps taking loads.
module mesh_bounding_box_fit #(
  parameter int unsigned MAX_VERTICES = mbbf_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mbbf_in_if.sink           in_ch,
  mbbf_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import mbbf_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // Configuration registers, read live by every fit and fetch.
  logic [31:0] target_r;
  coord_t      cx_r, cy_r, cz_r;
  logic        mirror_r;

  // Set state: counts, the shared box and the outcome of the last fit.
  logic [CW-1:0] vertex_count_r, usable_count_r;
  coord_t        box_min_r [3];
  coord_t        box_max_r [3];
  coord_t        box_mid_r [3];
  logic [31:0]   scale_r;
  logic          overflowed_r, fit_done_r, pass_r;

  fsm_t fsm_r, fsm_nxt;

  // The result is built here, then moved to the output register.
  logic        res_kind_r;
  logic [2:0]  res_status_r;
  coord_t      res_x_r, res_y_r, res_z_r;
  logic [31:0] res_scale_r;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [2:0]  out_status_r;
  coord_t      out_x_r, out_y_r, out_z_r;
  logic [31:0] out_scale_r;

  logic          acc;
  logic          load_acc, fit_acc, fetch_acc;
  logic [CW-1:0] eff_count, eff_usable;
  logic          full;
  logic          bad_fetch;
  coord_t        in_v [3];
  logic [31:0]   span [3];
  logic [31:0]   extent;
  logic          emit_go;
  logic [95:0]   rd_data;
  coord_t        rd_v [3];
  coord_t        center_a [3];
  logic [DIV_W-1:0] quot;
  unit_sts_t     div_sts, xf_sts;
  xf_ctl_t       xf_ctl;
  coord_t        xf_res [3];
  logic [32:0]   mid_sum [3];

  assign in_v[0] = in_ch.vertex_x;
  assign in_v[1] = in_ch.vertex_y;
  assign in_v[2] = in_ch.vertex_z;

  assign center_a[0] = cx_r;
  assign center_a[1] = cy_r;
  assign center_a[2] = cz_r;

  assign in_ch.ready = (fsm_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign load_acc    = acc && (in_ch.operation == OP_LOAD);
  assign fit_acc     = acc && (in_ch.operation == OP_FIT);
  assign fetch_acc   = acc && (in_ch.operation == OP_FETCH);

  // A load after a successful fit opens a new set, so it sees empty counts.
  assign eff_count  = fit_done_r ? '0 : vertex_count_r;
  assign eff_usable = fit_done_r ? '0 : usable_count_r;
  assign full       = (eff_count == CW'(MAX_VERTICES));

  assign bad_fetch = !fit_done_r || (32'(in_ch.fetch_index) >= 32'(vertex_count_r));

  // Spans are never negative, since min never passes max.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      span[k]    = 32'({box_max_r[k][31], box_max_r[k]} - {box_min_r[k][31], box_min_r[k]});
      mid_sum[k] = {box_min_r[k][31], box_min_r[k]} + {box_max_r[k][31], box_max_r[k]};
    end
    extent = span[0];
    if (span[1] > extent) extent = span[1];
    if (span[2] > extent) extent = span[2];
  end

  assign emit_go = !out_valid_r || out_ch.ready;

  mbbf_ram #(
    .WIDTH(3 * COORD_W),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (load_acc && !full),
    .waddr(AW'(eff_count)),
    .wdata({in_ch.vertex_x, in_ch.vertex_y, in_ch.vertex_z}),
    .re   (fetch_acc && !bad_fetch),
    .raddr(AW'(in_ch.fetch_index)),
    .rdata(rd_data)
  );

  assign rd_v[0] = rd_data[95:64];
  assign rd_v[1] = rd_data[63:32];
  assign rd_v[2] = rd_data[31:0];

  // Scale is (target << 16) / extent.
  mbbf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   ((fsm_r == S_EXTENT) && (extent != '0)),
    .dividend({target_r, 16'h0000}),
    .divisor (extent),
    .sts     (div_sts),
    .quotient(quot)
  );

  assign xf_ctl.start  = (fsm_r == S_FETCH) && !pass_r;
  assign xf_ctl.mirror = mirror_r;
  assign xf_ctl.scale  = scale_r;

  mbbf_xform u_xform (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (xf_ctl),
    .vtx   (rd_v),
    .mid   (box_mid_r),
    .center(center_a),
    .sts   (xf_sts),
    .res   (xf_res)
  );

  // Next state. Early fit outcomes and bad fetches go straight to the emit step.
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      S_IDLE: begin
        if (fit_acc) begin
          if (overflowed_r || (target_r == '0) || (usable_count_r == '0)) begin
            fsm_nxt = S_EMIT;
          end else begin
            fsm_nxt = S_EXTENT;
          end
        end else if (fetch_acc) begin
          fsm_nxt = bad_fetch ? S_EMIT : S_FETCH;
        end
      end
      S_EXTENT: fsm_nxt = (extent == '0) ? S_EMIT : S_DIVIDE;
      S_DIVIDE: if (div_sts.done) fsm_nxt = S_EMIT;
      S_FETCH:  fsm_nxt = pass_r ? S_EMIT : S_XFORM;
      S_XFORM:  if (xf_sts.done) fsm_nxt = S_EMIT;
      S_EMIT:   if (emit_go) fsm_nxt = S_IDLE;
      default:  fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r          <= S_IDLE;
      target_r       <= '0;
      cx_r           <= '0;
      cy_r           <= '0;
      cz_r           <= '0;
      mirror_r       <= 1'b1;
      vertex_count_r <= '0;
      usable_count_r <= '0;
      scale_r        <= '0;
      overflowed_r   <= 1'b0;
      fit_done_r     <= 1'b0;
      pass_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        box_min_r[k] <= '0;
        box_max_r[k] <= '0;
        box_mid_r[k] <= '0;
      end
    end else begin
      fsm_r <= fsm_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET:   target_r <= cfg_wdata;
          REG_CENTER_X: cx_r     <= cfg_wdata;
          REG_CENTER_Y: cy_r     <= cfg_wdata;
          REG_CENTER_Z: cz_r     <= cfg_wdata;
          REG_MIRROR_Y: mirror_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (load_acc) begin
        // A new set never starts full, so the count and, for a usable vertex,
        // the box are written below; only what they leave alone is cleared here.
        if (fit_done_r) begin
          overflowed_r <= 1'b0;
          fit_done_r   <= 1'b0;
          if (!in_ch.vertex_usable) begin
            usable_count_r <= '0;
            for (int k = 0; k < 3; k++) begin
              box_min_r[k] <= '0;
              box_max_r[k] <= '0;
            end
          end
        end
        if (full) begin
          overflowed_r <= 1'b1;
        end else begin
          vertex_count_r <= eff_count + CW'(1);
          if (in_ch.vertex_usable) begin
            usable_count_r <= eff_usable + CW'(1);
            for (int k = 0; k < 3; k++) begin
              if (eff_usable == '0) begin
                box_min_r[k] <= in_v[k];
                box_max_r[k] <= in_v[k];
              end else if (in_v[k] < box_min_r[k]) begin
                box_min_r[k] <= in_v[k];
              end else if (in_v[k] > box_max_r[k]) begin
                box_max_r[k] <= in_v[k];
              end
            end
          end
        end
      end

      // A zero target is a pass-through fit that succeeds unless the set overflowed.
      if (fit_acc && !overflowed_r && (target_r == '0)) begin
        pass_r     <= 1'b1;
        scale_r    <= UNIT_SCALE;
        fit_done_r <= 1'b1;
      end

      if ((fsm_r == S_DIVIDE) && div_sts.done && (quot != '0)
          && (quot[DIV_W-1:32] == '0)) begin
        scale_r    <= quot[31:0];
        pass_r     <= 1'b0;
        fit_done_r <= 1'b1;
        for (int k = 0; k < 3; k++) begin
          box_mid_r[k] <= mid_sum[k][32:1];
        end
      end

      if ((fsm_r == S_EMIT) && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result staging; the fields are filled by whichever step ends the beat.
  always_ff @(posedge clk) begin
    case (fsm_r)
      S_IDLE: begin
        res_x_r     <= '0;
        res_y_r     <= '0;
        res_z_r     <= '0;
        res_scale_r <= '0;
        if (fit_acc) begin
          res_kind_r <= KIND_FIT;
          if (overflowed_r) begin
            res_status_r <= STS_OVERFLOW;
          end else if (target_r == '0) begin
            res_status_r <= STS_OK;
            res_scale_r  <= UNIT_SCALE;
          end else begin
            res_status_r <= STS_NO_USABLE;
          end
        end else if (fetch_acc) begin
          res_kind_r   <= KIND_VERTEX;
          res_status_r <= STS_BAD_FETCH;
        end
      end
      S_EXTENT: res_status_r <= STS_ZERO_EXTENT;
      S_DIVIDE: begin
        if (div_sts.done) begin
          if ((quot == '0) || (quot[DIV_W-1:32] != '0)) begin
            res_status_r <= STS_SCALE_RANGE;
          end else begin
            res_status_r <= STS_OK;
            res_scale_r  <= quot[31:0];
          end
        end
      end
      S_FETCH: begin
        res_status_r <= STS_OK;
        res_scale_r  <= scale_r;
        res_x_r      <= rd_v[0];
        res_y_r      <= rd_v[1];
        res_z_r      <= rd_v[2];
      end
      S_XFORM: begin
        if (xf_sts.done) begin
          res_x_r <= xf_res[0];
          res_y_r <= xf_res[1];
          res_z_r <= xf_res[2];
        end
      end
      default: ;
    endcase
  end

  // Output register: loaded only when empty or being drained this cycle.
  always_ff @(posedge clk) begin
    if ((fsm_r == S_EMIT) && emit_go) begin
      out_kind_r   <= res_kind_r;
      out_status_r <= res_status_r;
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_z_r      <= res_z_r;
      out_scale_r  <= res_scale_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_x       = out_x_r;
  assign out_ch.out_y       = out_y_r;
  assign out_ch.out_z       = out_z_r;
  assign out_ch.fit_scale   = out_scale_r;
endmodule

/* design/mbbf_checker.sv */
`include "mesh_bounding_box_fit_macros.svh"

module mbbf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [2:0]  status,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic [31:0] fit_scale
);
  import mbbf_pkg::*;

  `MBBF_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result beat dropped")
  `MBBF_ASSERT_NOW(a_fit_zero_xyz, out_valid && (result_kind == KIND_FIT), (out_x == '0) && (out_y == '0) && (out_z == '0), "fit result carries coordinates")
  `MBBF_ASSERT_NOW(a_fail_no_scale, out_valid && (status != STS_OK), fit_scale == '0, "failed beat carries a scale")
  `MBBF_ASSERT_NOW(a_ok_fetch_scale, out_valid && (result_kind == KIND_VERTEX) && (status == STS_OK), fit_scale != '0, "good fetch without a scale")
endmodule

bind mesh_bounding_box_fit mbbf_checker u_mbbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .result_kind(out_ch.result_kind),
  .status     (out_ch.status),
  .out_x      (out_ch.out_x),
  .out_y      (out_ch.out_y),
  .out_z      (out_ch.out_z),
  .fit_scale  (out_ch.fit_scale)
);
